[hw/rtl/depth_layer_table_defines.svh]
// Assertion macros used by the depth layer table checker.
`ifndef DEPTH_LAYER_TABLE_DEFINES_SVH
`define DEPTH_LAYER_TABLE_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent.
`define DLT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define DLT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/dlt_pkg.sv]
// Shared types and constants of the depth layer table.
package dlt_pkg;

  // Operation codes of an input beat
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // One stored layer: upper depth, lower depth, permeability
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned ENTRY_W = 3 * VAL_W;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISS    = 2'd3
  } status_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic    load_item;
    logic    idx_inc;
    logic    idx_dec;
    logic    idx_to_count;
    logic    pos_from_idx;
    logic    pos_from_count;
    logic    ram_re;
    logic    rd_prev;
    logic    we_shift;
    logic    we_new;
    logic    count_inc;
    logic    res_load;
    status_e res_code;
    logic    res_take_perm;
    logic    emit;
  } dlt_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic is_lookup;
    logic invalid;
    logic full;
    logic empty;
    logic lower_lt_up;
    logic q_lt_lower;
    logic hit;
    logic last;
    logic shift_done;
  } dlt_sts_t;

endpackage

[hw/rtl/dlt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module dlt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/dlt_ctrl.sv]
// Sequencer of the depth layer table: scan, shift, write and result handoff.
module dlt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  dlt_pkg::dlt_sts_t sts_i,
  output dlt_pkg::dlt_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SHIFT_CHK,
    S_SHIFT_WR,
    S_WRITE,
    S_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  dlt_pkg::dlt_cmd_t cmd;

  // Next state and datapath commands
  always_comb begin
    cmd     = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.load_item = 1'b1;
          state_d       = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (!sts_i.is_lookup) begin
          if (sts_i.invalid) begin
            cmd.res_load = 1'b1;
            cmd.res_code = dlt_pkg::ST_INVALID;
            state_d      = S_FINISH;
          end else if (sts_i.full) begin
            cmd.res_load = 1'b1;
            cmd.res_code = dlt_pkg::ST_FULL;
            state_d      = S_FINISH;
          end else if (sts_i.empty) begin
            cmd.pos_from_count = 1'b1;
            state_d            = S_WRITE;
          end else begin
            state_d = S_SCAN_RD;
          end
        end else if (sts_i.empty) begin
          cmd.res_load = 1'b1;
          cmd.res_code = dlt_pkg::ST_MISS;
          state_d      = S_FINISH;
        end else begin
          state_d = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        cmd.ram_re = 1'b1;
        state_d    = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (!sts_i.is_lookup) begin
          // Insert in front of the first entry whose lower depth lies below the new upper depth
          if (sts_i.lower_lt_up) begin
            cmd.pos_from_idx = 1'b1;
            cmd.idx_to_count = 1'b1;
            state_d          = S_SHIFT_CHK;
          end else if (sts_i.last) begin
            cmd.pos_from_count = 1'b1;
            cmd.idx_to_count   = 1'b1;
            state_d            = S_SHIFT_CHK;
          end else begin
            cmd.idx_inc = 1'b1;
            state_d     = S_SCAN_RD;
          end
        end else if (!sts_i.last && sts_i.q_lt_lower) begin
          cmd.idx_inc = 1'b1;
          state_d     = S_SCAN_RD;
        end else begin
          cmd.res_load      = 1'b1;
          cmd.res_code      = sts_i.hit ? dlt_pkg::ST_OK : dlt_pkg::ST_MISS;
          cmd.res_take_perm = sts_i.hit;
          state_d           = S_FINISH;
        end
      end
      S_SHIFT_CHK: begin
        if (sts_i.shift_done) begin
          state_d = S_WRITE;
        end else begin
          cmd.ram_re  = 1'b1;
          cmd.rd_prev = 1'b1;
          state_d     = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        cmd.we_shift = 1'b1;
        cmd.idx_dec  = 1'b1;
        state_d      = S_SHIFT_CHK;
      end
      S_WRITE: begin
        cmd.we_new    = 1'b1;
        cmd.count_inc = 1'b1;
        cmd.res_load  = 1'b1;
        cmd.res_code  = dlt_pkg::ST_OK;
        state_d       = S_FINISH;
      end
      S_FINISH: begin
        // Hand the result over once the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd.emit = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Output beat valid: set on emit, drop when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule

[hw/rtl/dlt_dpath.sv]
// Datapath of the depth layer table: item registers, indexes, layer memory, result.
module dlt_dpath #(
  parameter int unsigned MAX_LAYERS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      operation_i,
  input  logic [31:0]               layer_permeability_i,
  input  logic signed [31:0]        upper_depth_i,
  input  logic signed [31:0]        lower_depth_i,
  input  logic                      swap_if_reversed_i,
  input  logic signed [31:0]        query_depth_i,
  input  dlt_pkg::dlt_cmd_t         cmd_i,
  output dlt_pkg::dlt_sts_t         sts_o,
  output logic [31:0]               found_permeability_o,
  output logic [1:0]                status_o,
  output logic [4:0]                layer_count_o
);

  localparam int unsigned AW = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
  localparam int unsigned CW = $clog2(MAX_LAYERS + 1);
  localparam int unsigned VW = dlt_pkg::VAL_W;
  localparam int unsigned EW = dlt_pkg::ENTRY_W;

  logic                 op_q;
  logic [VW-1:0]        perm_q;
  logic signed [VW-1:0] up_q, lo_q, qd_q;
  logic [CW-1:0]        idx_q, idx_d;
  logic [CW-1:0]        pos_q, pos_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [VW-1:0]        res_found_q;
  dlt_pkg::status_e     res_status_q;
  logic [VW-1:0]        out_found_q;
  dlt_pkg::status_e     out_status_q;
  logic [4:0]           out_count_q;

  logic                 swap;
  logic [EW-1:0]        rdata, wdata;
  logic signed [VW-1:0] rd_upper, rd_lower;
  logic [VW-1:0]        rd_perm;
  logic [CW-1:0]        raddr, waddr;
  logic [CW+4:0]        cnt_ext;

  // Swap a reversed pair of depths on request
  assign swap = swap_if_reversed_i && (upper_depth_i < lower_depth_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      op_q   <= operation_i;
      perm_q <= layer_permeability_i;
      up_q   <= swap ? lower_depth_i : upper_depth_i;
      lo_q   <= swap ? upper_depth_i : lower_depth_i;
      qd_q   <= query_depth_i;
    end
  end

  // Scan/shift index, insert position and layer count
  always_comb begin
    idx_d = idx_q;
    pos_d = pos_q;
    cnt_d = cnt_q;
    if (cmd_i.load_item) begin
      idx_d = '0;
    end else if (cmd_i.idx_to_count) begin
      idx_d = cnt_q;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + CW'(1);
    end else if (cmd_i.idx_dec) begin
      idx_d = idx_q - CW'(1);
    end
    if (cmd_i.pos_from_idx) begin
      pos_d = idx_q;
    end else if (cmd_i.pos_from_count) begin
      pos_d = cnt_q;
    end
    if (cmd_i.count_inc) begin
      cnt_d = cnt_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      pos_q <= '0;
      cnt_q <= '0;
    end else begin
      idx_q <= idx_d;
      pos_q <= pos_d;
      cnt_q <= cnt_d;
    end
  end

  // Layer memory: shift moves entry idx-1 up to idx, insert writes at pos
  assign raddr = cmd_i.rd_prev ? (idx_q - CW'(1)) : idx_q;
  assign waddr = cmd_i.we_new ? pos_q : idx_q;
  assign wdata = cmd_i.we_new ? {up_q, lo_q, perm_q} : rdata;

  dlt_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_LAYERS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.we_shift | cmd_i.we_new),
    .waddr_i (waddr[AW-1:0]),
    .wdata_i (wdata),
    .re_i    (cmd_i.ram_re),
    .raddr_i (raddr[AW-1:0]),
    .rdata_o (rdata)
  );

  assign rd_upper = $signed(rdata[EW-1 -: VW]);
  assign rd_lower = $signed(rdata[EW-VW-1 -: VW]);
  assign rd_perm  = rdata[VW-1:0];

  // Status toward the controller
  always_comb begin
    sts_o.is_lookup   = (op_q == dlt_pkg::OP_LOOKUP);
    sts_o.invalid     = (perm_q == '0) || !(up_q > lo_q);
    sts_o.full        = (cnt_q == CW'(MAX_LAYERS));
    sts_o.empty       = (cnt_q == '0);
    sts_o.lower_lt_up = (rd_lower < up_q);
    sts_o.q_lt_lower  = (qd_q < rd_lower);
    sts_o.hit         = (qd_q <= rd_upper) && (qd_q >= rd_lower);
    sts_o.last        = ((idx_q + CW'(1)) == cnt_q);
    sts_o.shift_done  = (idx_q == pos_q);
  end

  // Hold the result, then move it into the output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      res_found_q  <= cmd_i.res_take_perm ? rd_perm : '0;
      res_status_q <= cmd_i.res_code;
    end
    if (cmd_i.emit) begin
      out_found_q  <= res_found_q;
      out_status_q <= res_status_q;
      out_count_q  <= cnt_ext[4:0];
    end
  end

  assign cnt_ext              = {5'b0, cnt_q};
  assign found_permeability_o = out_found_q;
  assign status_o             = out_status_q;
  assign layer_count_o        = out_count_q;

endmodule

[hw/rtl/depth_layer_table.sv]
// Top level of the depth layer table.
// Keeps an ordered table of up to MAX_LAYERS depth layers (upper, lower, permeability,
// all Q16.16) in a layer memory with one write port and one registered read port, and
// serves one insert or lookup beat at a time; the next beat is taken while the previous
// result still waits at the output. The memory is read or written once a cycle, so entry
// accesses set the cost: a lookup reads entries in order until it stops; an insert reads
// entries up to its position, then moves each later entry up one place and writes the new
// one (only the write on an empty table); rejected inserts and lookups on an empty table
// touch no entry. The input reopens on the edge that raises the result; a result still
// stalled at the output holds the following one back until it is taken. No clearing pass
// follows reset: entries beyond the layer count are never read.
module depth_layer_table #(
  parameter int unsigned MAX_LAYERS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               operation_i,
  input  logic [31:0]        layer_permeability_i,
  input  logic signed [31:0] upper_depth_i,
  input  logic signed [31:0] lower_depth_i,
  input  logic               swap_if_reversed_i,
  input  logic signed [31:0] query_depth_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [31:0]        found_permeability_o,
  output logic [1:0]         status_o,
  output logic [4:0]         layer_count_o
);

  dlt_pkg::dlt_cmd_t cmd;
  dlt_pkg::dlt_sts_t sts;

  dlt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  dlt_dpath #(
    .MAX_LAYERS (MAX_LAYERS)
  ) u_dpath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .operation_i          (operation_i),
    .layer_permeability_i (layer_permeability_i),
    .upper_depth_i        (upper_depth_i),
    .lower_depth_i        (lower_depth_i),
    .swap_if_reversed_i   (swap_if_reversed_i),
    .query_depth_i        (query_depth_i),
    .cmd_i                (cmd),
    .sts_o                (sts),
    .found_permeability_o (found_permeability_o),
    .status_o             (status_o),
    .layer_count_o        (layer_count_o)
  );

endmodule

[hw/rtl/dlt_checker.sv]
// Port-level checks of the depth layer table and their binding.
`include "depth_layer_table_defines.svh"

module dlt_checker #(
  parameter int unsigned MAX_LAYERS = 16
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] found_permeability_o,
  input logic [1:0]  status_o,
  input logic [4:0]  layer_count_o
);

  localparam logic [4:0] FULL_COUNT = 5'(MAX_LAYERS);

  // Only one beat is in flight: taking one closes the input for the next cycle
  `DLT_ASSERT_NEXT(a_one_in_flight, in_valid_i && in_ready_o, !in_ready_o,
                   "second beat taken while busy")

  // Anything but a hit carries zero permeability
  `DLT_ASSERT_NOW(a_zero_on_miss, out_valid_o && (status_o != dlt_pkg::ST_OK),
                  found_permeability_o == '0, "nonzero permeability without a hit")

  // A full refusal reports a full table
  `DLT_ASSERT_NOW(a_full_count, out_valid_o && (status_o == dlt_pkg::ST_FULL),
                  layer_count_o == FULL_COUNT, "full status with a partial count")

  // A stalled result beat holds
  `DLT_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
                   out_valid_o && $stable(status_o) && $stable(found_permeability_o)
                   && $stable(layer_count_o), "result beat changed while stalled")

endmodule

bind depth_layer_table dlt_checker #(.MAX_LAYERS(MAX_LAYERS)) u_dlt_checker (.*);
